>>> hw/rtl/lxf_pkg.sv
// ----------------------------------------------------------------------------
// lxf_pkg
// Shared widths, register indexes and the step flags of the label expansion
// block.
// ----------------------------------------------------------------------------
package lxf_pkg;

    // payload and register widths
    localparam int DATA_W            = 32;
    localparam int WIDTH_W           = 11;
    localparam int HEIGHT_W          = 16;
    localparam int CFG_IDX_W         = 2;
    localparam int ROW_W             = 17;
    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int MIN_DIM           = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAG    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // register reset values
    localparam logic [DATA_W-1:0]   TAG_RESET    = '0;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd3;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd3;

    // per-item control decided at the sequencer, carried with the item
    typedef struct packed {
        logic has_result;
        logic last;
        logic bank;
        logic ok_above;
        logic ok_left;
        logic ok_right;
        logic ok_below;
    } t_flags;

endpackage

>>> hw/rtl/lxf_ram.sv
// ----------------------------------------------------------------------------
// lxf_ram
// Single-port-write, single-port-read line memory, registered read data,
// read of the entry being written returns the old contents.
// ----------------------------------------------------------------------------
module lxf_ram #(
    parameter int DEPTH = lxf_pkg::DEFAULT_MAX_WIDTH,
    parameter int WIDTH = lxf_pkg::DATA_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read before write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/lxf_seq.sv
// ----------------------------------------------------------------------------
// lxf_seq
// Raster position sequencer: column and row counters, line memory addresses
// and the neighbour validity flags for each item.
// ----------------------------------------------------------------------------
module lxf_seq #(
    parameter int MAX_WIDTH = lxf_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_drain,
    input  logic [lxf_pkg::WIDTH_W-1:0]   i_width,
    input  logic [lxf_pkg::HEIGHT_W-1:0]  i_height,
    output logic                          o_noop,
    output logic                          o_wr,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_col,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_col_nxt,
    output lxf_pkg::t_flags               o_flags
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int XW  = WW + 2;
    localparam int RW  = lxf_pkg::ROW_W;
    localparam int RXW = RW + 1;

    logic [CW-1:0]  r_col;
    logic [CW-1:0]  n_col;
    logic [RW-1:0]  r_row;
    logic [RW-1:0]  n_row;

    logic [31:0]    w32;
    logic [WW-1:0]  w_eff;
    logic [lxf_pkg::HEIGHT_W-1:0] h_eff;
    logic [XW-1:0]  wx;
    logic [XW-1:0]  cx;
    logic [XW-1:0]  cx_inc;
    logic [RXW-1:0] hx;
    logic [RXW-1:0] tx;
    logic [CW-1:0]  c0;
    logic [RW-1:0]  r0;
    logic           flush;
    logic           col_in;
    logic           row_in;

    // effective frame size
    always_comb begin
        w32 = {{(32-lxf_pkg::WIDTH_W){1'b0}}, i_width};
        if (w32 < 32'(lxf_pkg::MIN_DIM)) begin
            w32 = 32'(lxf_pkg::MIN_DIM);
        end else if (w32 > 32'(MAX_WIDTH)) begin
            w32 = 32'(MAX_WIDTH);
        end
        w_eff = w32[WW-1:0];
        if (i_height < lxf_pkg::HEIGHT_W'(lxf_pkg::MIN_DIM)) begin
            h_eff = lxf_pkg::HEIGHT_W'(lxf_pkg::MIN_DIM);
        end else begin
            h_eff = i_height;
        end
    end

    // position of this item, wrapping a column count left beyond the width
    always_comb begin
        wx = XW'(w_eff);
        hx = RXW'(h_eff);
        if (XW'(r_col) >= wx) begin
            c0 = '0;
            r0 = r_row + RW'(1);
        end else begin
            c0 = r_col;
            r0 = r_row;
        end
        flush  = RXW'(r0) >= hx;
        cx     = XW'(c0);
        cx_inc = cx + XW'(1);
        tx     = RXW'(r0) - RXW'(1);
    end

    // neighbour validity, target row is the row above the incoming one
    always_comb begin
        col_in = (cx >= XW'(1)) && (cx + XW'(2) <= wx);
        row_in = (tx >= RXW'(1)) && (tx + RXW'(2) <= hx);
        o_flags.has_result = (r0 != '0);
        o_flags.last       = (tx + RXW'(1) == hx) && (cx_inc == wx);
        o_flags.bank       = r0[0];
        o_flags.ok_above   = (tx >= RXW'(2)) && (tx + RXW'(1) <= hx) && col_in;
        o_flags.ok_left    = row_in && (cx >= XW'(2));
        o_flags.ok_right   = row_in && (cx + XW'(3) <= wx);
        o_flags.ok_below   = !flush && (tx + RXW'(3) <= hx) && col_in;
    end

    assign o_noop = i_drain && !flush;
    assign o_wr   = !flush;
    assign o_col  = c0;
    // next column address, folded back at the memory depth
    assign o_col_nxt = (cx_inc == XW'(MAX_WIDTH)) ? '0 : cx_inc[CW-1:0];

    // counter advance
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_adv) begin
            if (o_noop) begin
                n_col = c0;
                n_row = r0;
            end else if (cx_inc >= wx) begin
                n_col = '0;
                n_row = flush ? '0 : r0 + RW'(1);
            end else begin
                n_col = cx_inc[CW-1:0];
                n_row = r0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

>>> hw/rtl/lxf_pick.sv
// ----------------------------------------------------------------------------
// lxf_pick
// Neighbour selection: a target pixel equal to the tag takes the first usable
// label among above, left, right and below.
// ----------------------------------------------------------------------------
module lxf_pick (
    input  logic [lxf_pkg::DATA_W-1:0] i_tag,
    input  logic [lxf_pkg::DATA_W-1:0] i_dst,
    input  logic [lxf_pkg::DATA_W-1:0] i_above,
    input  logic [lxf_pkg::DATA_W-1:0] i_left,
    input  logic [lxf_pkg::DATA_W-1:0] i_right,
    input  logic [lxf_pkg::DATA_W-1:0] i_below,
    input  lxf_pkg::t_flags            i_flags,
    output logic [lxf_pkg::DATA_W-1:0] o_value
);

    logic use_above;
    logic use_left;
    logic use_right;
    logic use_below;

    // usable: valid neighbour, nonzero and not the tag itself
    assign use_above = i_flags.ok_above && (i_above != '0) && (i_above != i_tag);
    assign use_left  = i_flags.ok_left  && (i_left  != '0) && (i_left  != i_tag);
    assign use_right = i_flags.ok_right && (i_right != '0) && (i_right != i_tag);
    assign use_below = i_flags.ok_below && (i_below != '0) && (i_below != i_tag);

    // priority select
    always_comb begin
        o_value = i_dst;
        if (i_dst == i_tag) begin
            if (use_above) begin
                o_value = i_above;
            end else if (use_left) begin
                o_value = i_left;
            end else if (use_right) begin
                o_value = i_right;
            end else if (use_below) begin
                o_value = i_below;
            end
        end
    end

endmodule

>>> hw/rtl/label_expand_four_neighbour.sv
// ----------------------------------------------------------------------------
// label_expand_four_neighbour
// One pass of four-neighbour label growth over a streamed pair of images.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one pixel pair per item in
//   raster order: source label, target value, and a drain flag. Output
//   channel (o_valid / i_stall) carries the updated target pixel and a flag
//   on the last pixel of the frame. Tag, width and height are written through
//   the plain write port while the block is idle.
//   Results lag the input by one image row: the pixel at column c of row r
//   releases the target pixel at column c of row r-1 through the selection
//   stage and the output register. After the last pixel, width further items
//   (drain or not) flush the last row; drain items during pixel rows are
//   dropped. Throughput is one item per cycle while o_stall is low, set by
//   the source line memories: two row banks, each read once and written at
//   most once per cycle, plus one target row memory.
//   Reset clears the position counters, the registers and the pipeline; line
//   memories are not cleared and are only read where written in this frame.
//   When the receiver stalls, the output register holds its item, the
//   selection stage holds one more, and then o_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module label_expand_four_neighbour #(
    parameter int MAX_WIDTH = lxf_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [lxf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lxf_pkg::DATA_W-1:0]      i_cfg_data,
    // input items
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [lxf_pkg::DATA_W-1:0] i_src_label,
    input  logic signed [lxf_pkg::DATA_W-1:0] i_dst_value,
    input  logic                            i_drain,
    // result items
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [lxf_pkg::DATA_W-1:0] o_out_value,
    output logic                            o_out_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = lxf_pkg::DATA_W;

    logic [DW-1:0]                r_tag;
    logic [lxf_pkg::WIDTH_W-1:0]  r_width;
    logic [lxf_pkg::HEIGHT_W-1:0] r_height;

    logic                         accept;
    logic                         load;
    logic                         s1_go;
    logic                         noop;
    logic                         wr;
    logic [CW-1:0]                col;
    logic [CW-1:0]                col_nxt;
    lxf_pkg::t_flags              flags;

    logic                         r_s1_valid;
    lxf_pkg::t_flags              r_s1_flags;
    logic [DW-1:0]                r_s1_src;
    logic [DW-1:0]                r_win1;
    logic [DW-1:0]                r_win2;

    logic [DW-1:0]                bank0_rd;
    logic [DW-1:0]                bank1_rd;
    logic [DW-1:0]                dst_rd;
    logic [DW-1:0]                above;
    logic [DW-1:0]                right;
    logic [DW-1:0]                pick_value;

    logic                         r_out_valid;
    logic [DW-1:0]                r_out_value;
    logic                         r_out_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag    <= lxf_pkg::TAG_RESET;
            r_width  <= lxf_pkg::WIDTH_RESET;
            r_height <= lxf_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lxf_pkg::CFG_TAG:    r_tag    <= i_cfg_data;
                lxf_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[lxf_pkg::WIDTH_W-1:0];
                lxf_pkg::CFG_HEIGHT: r_height <= i_cfg_data[lxf_pkg::HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake: selection stage moves on when the output register is free or its item has no result
    assign s1_go   = r_s1_valid && (!r_s1_flags.has_result || !r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_go;
    assign accept  = i_valid && !o_stall;
    assign load    = accept && !noop;

    // raster sequencer
    lxf_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (accept),
        .i_drain   (i_drain),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_noop    (noop),
        .o_wr      (wr),
        .o_col     (col),
        .o_col_nxt (col_nxt),
        .o_flags   (flags)
    );

    // source row banks: the current row's bank is read (row above target)
    // and rewritten at this column, the other bank is read one column ahead
    lxf_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (DW)
    ) u_src_bank0 (
        .i_clk   (i_clk),
        .i_we    (load && wr && !flags.bank),
        .i_waddr (col),
        .i_wdata (i_src_label),
        .i_re    (load),
        .i_raddr (flags.bank ? col_nxt : col),
        .o_rdata (bank0_rd)
    );

    lxf_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (DW)
    ) u_src_bank1 (
        .i_clk   (i_clk),
        .i_we    (load && wr && flags.bank),
        .i_waddr (col),
        .i_wdata (i_src_label),
        .i_re    (load),
        .i_raddr (flags.bank ? col : col_nxt),
        .o_rdata (bank1_rd)
    );

    // target row memory
    lxf_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (DW)
    ) u_dst_line (
        .i_clk   (i_clk),
        .i_we    (load && wr),
        .i_waddr (col),
        .i_wdata (i_dst_value),
        .i_re    (load),
        .i_raddr (col),
        .o_rdata (dst_rd)
    );

    // selection stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // selection stage payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_flags <= flags;
            r_s1_src   <= i_src_label;
        end
    end

    // bank routing
    assign above = r_s1_flags.bank ? bank1_rd : bank0_rd;
    assign right = r_s1_flags.bank ? bank0_rd : bank1_rd;

    // sliding window over the target row: current and left columns
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_win1 <= right;
            r_win2 <= r_win1;
        end
    end

    lxf_pick u_pick (
        .i_tag   (r_tag),
        .i_dst   (dst_rd),
        .i_above (above),
        .i_left  (r_win2),
        .i_right (right),
        .i_below (r_s1_src),
        .i_flags (r_s1_flags),
        .o_value (pick_value)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_flags.has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_flags.has_result) begin
            r_out_value <= pick_value;
            r_out_last  <= r_s1_flags.last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

>>> tb/tb_label_expand_four_neighbour.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_label_expand_four_neighbour
// Self-checking bench for the four-neighbour label growth block. A directed
// table covers reset settings, field extremes, ignored drains, pixels in the
// flush row, tag-valued labels and register saturation. Random frames of
// random size and tag follow, with gaps on both channels. Each result is
// compared with a typed-in value or a line-buffer model kept in the bench.
// ----------------------------------------------------------------------------
module tb_label_expand_four_neighbour;

    localparam int          MAXW         = lxf_pkg::DEFAULT_MAX_WIDTH;
    localparam int          RANDOM_ITEMS = 1040;
    localparam int          SETTLE       = 8;
    localparam int          TAIL         = 12;
    localparam int          LIMIT        = 200000;
    localparam int          PEND_DEPTH   = 64;
    localparam logic [31:0] Z            = 32'h0000_0000;
    localparam logic [31:0] ONES         = 32'hFFFF_FFFF;
    localparam logic [31:0] TMIN         = 32'h8000_0000;
    localparam logic [31:0] TMAX         = 32'h7FFF_FFFF;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // one row of the directed table: an item (a = source, b = target) or a
    // register write (a = data), with an optional typed-in result
    typedef struct packed {
        t_row_kind                     kind;
        logic [lxf_pkg::CFG_IDX_W-1:0] idx;
        logic [lxf_pkg::DATA_W-1:0]    a;
        logic [lxf_pkg::DATA_W-1:0]    b;
        logic                          drain;
        logic                          typed;
        logic                          has;
        logic [lxf_pkg::DATA_W-1:0]    val;
        logic                          last;
    } t_row;

    typedef struct packed {
        logic [lxf_pkg::DATA_W-1:0] value;
        logic                       last;
    } t_grown;

    localparam int DIR_ROWS = 28;
    localparam t_row DIR_TBL [DIR_ROWS] = '{
        // reset settings: tag 0, 3 x 3, only the centre pixel propagates
        '{ROW_ITEM, lxf_pkg::CFG_TAG, 32'd5, Z, 1'b0, 1'b1, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, TMIN, Z, 1'b0, 1'b1, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, 32'd7, TMAX, 1'b0, 1'b1, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, 32'd9, Z, 1'b0, 1'b1, 1'b1, Z, 1'b0},
        // drain inside the pixel rows is dropped
        '{ROW_ITEM, lxf_pkg::CFG_TAG, TMAX, TMAX, 1'b1, 1'b1, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, TMAX, Z, 1'b0, 1'b1, 1'b1, TMAX, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, ONES, TMIN, 1'b0, 1'b1, 1'b1, TMAX, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, 32'd3, Z, 1'b0, 1'b1, 1'b1, TMAX, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, 32'd4, Z, 1'b0, 1'b1, 1'b1, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, 32'd6, Z, 1'b0, 1'b1, 1'b1, TMIN, 1'b0},
        // flush row, a pixel item in it counts as a drain
        '{ROW_ITEM, lxf_pkg::CFG_TAG, Z, Z, 1'b1, 1'b1, 1'b1, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, 32'h1234_5678, ONES, 1'b0, 1'b1, 1'b1, TMAX, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, Z, Z, 1'b1, 1'b1, 1'b1, Z, 1'b1},
        // most negative tag, width and height below range saturate to 3
        '{ROW_CFG, lxf_pkg::CFG_TAG, TMIN, Z, 1'b0, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_CFG, lxf_pkg::CFG_WIDTH, Z, Z, 1'b0, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_CFG, lxf_pkg::CFG_HEIGHT, 32'd1, Z, 1'b0, 1'b0, 1'b0, Z, 1'b0},
        // centre label equal to tag must not spread
        '{ROW_ITEM, lxf_pkg::CFG_TAG, Z, TMIN, 1'b0, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, 32'd1, TMIN, 1'b0, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, Z, TMIN, 1'b0, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, ONES, TMIN, 1'b0, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, TMIN, TMIN, 1'b0, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, 32'd2, Z, 1'b0, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, 32'd3, TMIN, 1'b0, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, 32'd4, TMIN, 1'b0, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, 32'd5, TMIN, 1'b0, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, Z, Z, 1'b1, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, Z, Z, 1'b1, 1'b0, 1'b0, Z, 1'b0},
        '{ROW_ITEM, lxf_pkg::CFG_TAG, Z, Z, 1'b1, 1'b0, 1'b0, Z, 1'b0}
    };

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [lxf_pkg::CFG_IDX_W-1:0]       i_cfg_idx;
    logic [lxf_pkg::DATA_W-1:0]          i_cfg_data;
    logic                                i_valid;
    logic                                o_stall;
    logic signed [lxf_pkg::DATA_W-1:0]   i_src_label;
    logic signed [lxf_pkg::DATA_W-1:0]   i_dst_value;
    logic                                i_drain;
    logic                                o_valid;
    logic                                i_stall;
    logic signed [lxf_pkg::DATA_W-1:0]   o_out_value;
    logic                                o_out_last;

    // mirror of the block: registers, line stores and position
    logic [lxf_pkg::DATA_W-1:0]   m_tag;
    logic [lxf_pkg::WIDTH_W-1:0]  m_width;
    logic [lxf_pkg::HEIGHT_W-1:0] m_height;
    logic [lxf_pkg::DATA_W-1:0]   lbl_rows [2*MAXW];
    logic [lxf_pkg::DATA_W-1:0]   tgt_row [MAXW];
    int unsigned                  col_pos;
    int unsigned                  row_pos;

    // pending results in order, kept as a ring
    t_grown      pend_buf [PEND_DEPTH];
    int unsigned pend_wr = 0;
    int unsigned pend_rd = 0;
    t_grown      head;
    int unsigned mismatch_count = 0;
    int unsigned stall_left = 0;
    int unsigned cycles = 0;
    logic        idle_on = 1'b1;

    label_expand_four_neighbour u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_src_label (i_src_label),
        .i_dst_value (i_dst_value),
        .i_drain     (i_drain),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("label_expand_four_neighbour test failed");
            $finish;
        end
    end

    function automatic int unsigned eff_width();
        int unsigned wv;
        wv = m_width;
        if (wv < lxf_pkg::MIN_DIM) wv = lxf_pkg::MIN_DIM;
        if (wv > MAXW) wv = MAXW;
        return wv;
    endfunction

    function automatic int unsigned eff_height();
        return (m_height < lxf_pkg::MIN_DIM) ? lxf_pkg::MIN_DIM : m_height;
    endfunction

    function automatic logic [lxf_pkg::DATA_W-1:0] label_at(input int unsigned r,
                                                            input int unsigned c);
        if (c >= MAXW) return '0;
        return lbl_rows[(r & 1) * MAXW + c];
    endfunction

    // one step of label growth; returns 1 when the item releases a pixel
    function automatic logic grow_pixel(input logic [lxf_pkg::DATA_W-1:0] src,
                                        input logic [lxf_pkg::DATA_W-1:0] dst,
                                        input logic drain, output t_grown res);
        int unsigned                w;
        int unsigned                h;
        int unsigned                c;
        int unsigned                r;
        int unsigned                t;
        logic                       flush;
        logic                       col_in;
        logic                       row_in;
        logic                       found;
        logic [lxf_pkg::DATA_W-1:0] v;
        logic [3:0]                 nb_ok;
        logic [lxf_pkg::DATA_W-1:0] nb_lbl [4];
        w = eff_width();
        h = eff_height();
        flush = row_pos >= h;
        found = 1'b0;
        res = '0;
        // column count beyond a narrowed width wraps at once
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = row_pos + 1;
            flush = row_pos >= h;
        end
        if (drain && !flush) return 1'b0;
        c = col_pos;
        r = row_pos;
        if (r >= 1) begin
            t = r - 1;
            v = tgt_row[c];
            col_in = (c >= 1) && (c + 2 <= w);
            row_in = (t >= 1) && (t + 2 <= h);
            // neighbours in order above, left, right, below
            if (v == m_tag) begin
                nb_ok[0] = (t >= 2) && (t + 1 <= h) && col_in;
                nb_lbl[0] = nb_ok[0] ? label_at(t - 1, c) : '0;
                nb_ok[1] = row_in && (c >= 2);
                nb_lbl[1] = nb_ok[1] ? label_at(t, c - 1) : '0;
                nb_ok[2] = row_in && (c + 3 <= w);
                nb_lbl[2] = nb_ok[2] ? label_at(t, c + 1) : '0;
                nb_ok[3] = !flush && (t + 3 <= h) && col_in;
                nb_lbl[3] = nb_ok[3] ? src : '0;
                for (int k = 0; k < 4; k++) begin
                    if (!found && nb_ok[k] && nb_lbl[k] != '0 && nb_lbl[k] != m_tag) begin
                        v = nb_lbl[k];
                        found = 1'b1;
                    end
                end
            end
            res.value = v;
            res.last = (t + 1 == h) && (c + 1 == w);
        end
        if (!flush) begin
            lbl_rows[(r & 1) * MAXW + c] = src;
            tgt_row[c] = dst;
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = flush ? 0 : r + 1;
        end
        return r >= 1;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [lxf_pkg::DATA_W-1:0] got,
                                   input logic [lxf_pkg::DATA_W-1:0] want);
        if (mismatch_count < 100) begin
            $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
        end
        mismatch_count = mismatch_count + 1;
    endtask

    // register write, only once every pending pixel has come out
    task automatic write_reg(input logic [lxf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lxf_pkg::DATA_W-1:0] data);
        i_valid = 1'b0;
        while (pend_wr != pend_rd) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            lxf_pkg::CFG_TAG:    m_tag = data;
            lxf_pkg::CFG_WIDTH:  m_width = data[lxf_pkg::WIDTH_W-1:0];
            lxf_pkg::CFG_HEIGHT: m_height = data[lxf_pkg::HEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    // offer one item, wait for acceptance, queue the pixel it releases
    task automatic offer_item(input logic [lxf_pkg::DATA_W-1:0] src,
                              input logic [lxf_pkg::DATA_W-1:0] dst,
                              input logic drain, input logic typed, input logic t_has,
                              input logic [lxf_pkg::DATA_W-1:0] t_val, input logic t_last);
        int unsigned gap;
        t_grown      res;
        logic        has;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_src_label = src;
        i_dst_value = dst;
        i_drain = drain;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        has = grow_pixel(src, dst, drain, res);
        if (typed) begin
            has = t_has;
            res.value = t_val;
            res.last = t_last;
        end
        if (has) begin
            pend_buf[pend_wr % PEND_DEPTH] = res;
            pend_wr = pend_wr + 1;
        end
        @(negedge i_clk);
    endtask

    function automatic logic [lxf_pkg::DATA_W-1:0] pick_label();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3, 4:    return m_tag;
            5, 6, 7: return $urandom_range(1, 6);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [lxf_pkg::DATA_W-1:0] pick_target();
        case ($urandom_range(0, 19))
            0, 1, 2:    return $urandom_range(0, 6);
            3, 4, 5, 6: return $urandom();
            default:    return m_tag;
        endcase
    endfunction

    // result side: check against the oldest pending pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pend_wr == pend_rd) begin
                report_mismatch("result with none pending", o_out_value, '0);
            end else begin
                head = pend_buf[pend_rd % PEND_DEPTH];
                pend_rd = pend_rd + 1;
                if (o_out_value !== head.value) begin
                    report_mismatch("out_value", o_out_value, head.value);
                end
                if (o_out_last !== head.last) begin
                    report_mismatch("out_last", {31'd0, o_out_last}, {31'd0, head.last});
                end
            end
            stall_left = idle_on ? $urandom_range(0, 11) : 0;
        end
    end

    // receiver stall, drawn after each result
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                i_stall = 1'b1;
                stall_left = stall_left - 1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // stimulus
    initial begin
        t_row                       row;
        logic [lxf_pkg::DATA_W-1:0] tag_v;
        logic [lxf_pkg::DATA_W-1:0] w_raw;
        logic [lxf_pkg::DATA_W-1:0] h_raw;
        int unsigned                ew;
        int unsigned                eh;
        int unsigned                pause_at;
        int unsigned                frame;
        int unsigned                small_items;
        logic                       tall;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = lxf_pkg::CFG_TAG;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_src_label = '0;
        i_dst_value = '0;
        i_drain = 1'b0;
        m_tag = lxf_pkg::TAG_RESET;
        m_width = lxf_pkg::WIDTH_RESET;
        m_height = lxf_pkg::HEIGHT_RESET;
        for (int i = 0; i < 2 * MAXW; i++) lbl_rows[i] = '0;
        for (int i = 0; i < MAXW; i++) tgt_row[i] = '0;
        col_pos = 0;
        row_pos = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIR_TBL[i];
            if (row.kind == ROW_CFG) begin
                write_reg(row.idx, row.a);
            end else begin
                offer_item(row.a, row.b, row.drain, row.typed, row.has, row.val, row.last);
            end
        end

        // random frames, settings changed only between frames
        frame = 0;
        small_items = 0;
        while (small_items < RANDOM_ITEMS) begin
            tall = (frame == 4);
            case ($urandom_range(0, 5))
                0:       tag_v = Z;
                1:       tag_v = TMIN;
                2:       tag_v = TMAX;
                3:       tag_v = $urandom_range(1, 6);
                4:       tag_v = ONES;
                default: tag_v = $urandom();
            endcase
            write_reg(lxf_pkg::CFG_TAG, tag_v);
            if ($urandom_range(0, 7) == 0) w_raw = $urandom_range(0, 2);
            else w_raw = $urandom_range(3, 12);
            write_reg(lxf_pkg::CFG_WIDTH, w_raw);
            if (tall) begin
                write_reg(lxf_pkg::CFG_HEIGHT, 32'hFFFF);
                h_raw = $urandom_range(40, 60);
            end else if ($urandom_range(0, 7) == 0) begin
                h_raw = $urandom_range(0, 2);
            end else begin
                h_raw = $urandom_range(3, 8);
            end
            write_reg(lxf_pkg::CFG_HEIGHT, h_raw);
            ew = eff_width();
            eh = eff_height();
            idle_on = ($urandom_range(0, 3) != 0);
            pause_at = (frame == 0 || $urandom_range(0, 2) == 0) ?
                       $urandom_range(ew, ew * eh - 1) : ew * eh;

            // pixel rows with a few stray drains
            for (int p = 0; p < ew * eh; p++) begin
                if (p == pause_at) begin
                    i_valid = 1'b0;
                    do @(negedge i_clk); while (pend_wr != pend_rd);
                end
                if ($urandom_range(0, 19) == 0) begin
                    offer_item($urandom(), $urandom(), 1'b1, 1'b0, 1'b0, Z, 1'b0);
                end
                offer_item(pick_label(), pick_target(), 1'b0, 1'b0, 1'b0, Z, 1'b0);
            end
            // flush row, mostly drains
            for (int c = 0; c < ew; c++) begin
                offer_item($urandom(), $urandom(), ($urandom_range(0, 3) != 0),
                           1'b0, 1'b0, Z, 1'b0);
            end
            small_items = small_items + ew * (eh + 1);
            frame = frame + 1;
        end

        // wind down
        i_valid = 1'b0;
        do @(negedge i_clk); while (pend_wr != pend_rd);
        repeat (TAIL) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("label_expand_four_neighbour test passed");
        end else begin
            $display("label_expand_four_neighbour test failed");
        end
        $finish;
    end

endmodule
